### rtl/ett_pkg.sv
// shared types, constants and the cosine ease lookup for the tween block
`default_nettype none
package ett_pkg;

	// field widths
	localparam int COORD_W  = 16;
	localparam int TIME_W   = 24;
	localparam int DELTA_W  = 16;
	localparam int TOL_W    = 8;
	localparam int ACTION_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	// ratio format, unsigned Q1.16, one integer bit so that 1.0 fits
	localparam int RATIO_FRACTION_BITS = 16;
	localparam int RATIO_W = RATIO_FRACTION_BITS + 1;
	localparam logic [RATIO_W-1:0] ONE_RATIO = RATIO_W'(1) << RATIO_FRACTION_BITS;

	// ease lookup
	localparam int EASE_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(EASE_TABLE_DEPTH + 1);
	localparam int POS_W = RATIO_W + IDX_W;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(EASE_TABLE_DEPTH);

	// shared multiplier operand width, signed
	localparam int MUL_OP_W = ((COORD_W + 1) > RATIO_W ? (COORD_W + 1) : RATIO_W) + 1;
	localparam int MUL_P_W  = 2 * MUL_OP_W;

	// divider iteration count width
	localparam int DIV_CNT_W = $clog2(RATIO_W + 1);

	// command queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EASE_MODE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd6;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADVANCE = 2'd0,
		ACT_START   = 2'd1,
		ACT_STOP    = 2'd2,
		ACT_NOP     = 2'd3
	} action_t;

	typedef struct packed {
		action_t              act;
		logic [DELTA_W-1:0]   delta;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [TIME_W-1:0]         duration;
		logic                      ease_cos;
		logic [TOL_W-1:0]          tol;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [RATIO_W-1:0] quotient;
	} div_rsp_t;

	typedef logic [RATIO_W-1:0] ease_tab_t [EASE_TABLE_DEPTH+1];

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	// 0.5 - 0.5cos(pi j/depth) from a Q30 Taylor series, mirrored for the upper half
	function automatic ease_tab_t build_ease_tab();
		ease_tab_t   t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      acc;
		longint      v;
		for (int j = 0; j <= EASE_TABLE_DEPTH; j++) begin
			if (2 * j <= EASE_TABLE_DEPTH) begin
				x = (PI_Q30 * 64'(j)) / EASE_TABLE_DEPTH;
				x2 = (x * x) >> 30;
				term = ONE_Q30;
				acc = longint'(ONE_Q30);
				for (int k = 1; k <= 10; k++) begin
					term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
					if ((k % 2) == 1) acc = acc - longint'(term);
					else acc = acc + longint'(term);
				end
				if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
				if (acc < -longint'(ONE_Q30)) acc = -longint'(ONE_Q30);
				v = longint'(ONE_Q30) - acc;
				v = (v + (64'sd1 << (30 - RATIO_FRACTION_BITS))) >>> (31 - RATIO_FRACTION_BITS);
				if (v > (64'sd1 << RATIO_FRACTION_BITS)) v = 64'sd1 << RATIO_FRACTION_BITS;
				t[j] = v[RATIO_W-1:0];
			end else begin
				t[j] = ONE_RATIO - t[EASE_TABLE_DEPTH - j];
			end
		end
		return t;
	endfunction

	localparam ease_tab_t EASE_TAB = build_ease_tab();

endpackage
`default_nettype wire

### rtl/ett_if.sv
// command and result channel interfaces
`default_nettype none
interface ett_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [ett_pkg::ACTION_W-1:0]  action;
	logic [ett_pkg::DELTA_W-1:0]   delta_ticks;

	modport source(output valid, action, delta_ticks, input ready);
	modport sink(input valid, action, delta_ticks, output ready);
endinterface

interface ett_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [ett_pkg::COORD_W-1:0]  offset_x;
	logic signed [ett_pkg::COORD_W-1:0]  offset_y;
	logic                                moved;
	logic                                playing;

	modport source(output valid, offset_x, offset_y, moved, playing, input ready);
	modport sink(input valid, offset_x, offset_y, moved, playing, output ready);
endinterface
`default_nettype wire

### rtl/eased_translation_tween_core.sv
// top level of the eased translation tween: config registers, intake, divider, sequencer
// path: start, stop, no-op and an advance while stopped are answered straight from idle; an
//   advance while playing: divider if duration is nonzero, ease lookup if cosine, x and y lerps
// flow: a new word is taken only in idle, after the divider, shared multiplier and a
//   free result slot; the two-entry queue takes words until full while the sequencer works
// reset: arst_n clears config to zero, stops play, zeroes elapsed time and the offset
`default_nettype none
module eased_translation_tween_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ett_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ett_pkg::CFG_DATA_W-1:0]    cfg_data,
	ett_cmd_if.sink                                cmd,
	ett_res_if.source                              res
);

	ett_pkg::cfg_t      cfg_q;
	ett_pkg::cmd_t      q_word;
	logic               q_valid;
	logic               q_pop;
	ett_pkg::div_req_t  div_req;
	ett_pkg::div_rsp_t  div_rsp;

	// config regs read live by sequencer; user writes only while idle, not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ett_pkg::REG_START_X:   cfg_q.start_x <= cfg_data[ett_pkg::COORD_W-1:0];
				ett_pkg::REG_START_Y:   cfg_q.start_y <= cfg_data[ett_pkg::COORD_W-1:0];
				ett_pkg::REG_END_X:     cfg_q.end_x <= cfg_data[ett_pkg::COORD_W-1:0];
				ett_pkg::REG_END_Y:     cfg_q.end_y <= cfg_data[ett_pkg::COORD_W-1:0];
				ett_pkg::REG_DURATION:  cfg_q.duration <= cfg_data[ett_pkg::TIME_W-1:0];
				ett_pkg::REG_EASE_MODE: cfg_q.ease_cos <= cfg_data[0];
				ett_pkg::REG_TOLERANCE: cfg_q.tol <= cfg_data[ett_pkg::TOL_W-1:0];
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	// intake: classify and queue command words
	ett_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_word  (q_word),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// elapsed/duration ratio unit
	ett_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer owns the play state and the result register
	ett_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_word  (q_word),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.res     (res)
	);

endmodule
`default_nettype wire

### rtl/ett_front.sv
// command intake: accepts words, classifies the action and queues them
`default_nettype none
module ett_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	ett_cmd_if.sink           cmd,
	output ett_pkg::cmd_t     q_word,
	output logic              q_valid,
	input  wire logic         q_pop
);

	ett_pkg::cmd_t                 mem_q [ett_pkg::QUEUE_DEPTH];
	logic [ett_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ett_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ett_pkg::QCNT_W-1:0]    cnt_q;
	ett_pkg::cmd_t                 cls;
	logic                          push;
	logic                          pop;

	// delta only matters for an advance
	always_comb begin
		cls.act = ett_pkg::action_t'(cmd.action);
		cls.delta = (cls.act == ett_pkg::ACT_ADVANCE) ? cmd.delta_ticks : '0;
	end

	assign cmd.ready = (cnt_q != ett_pkg::QCNT_W'(ett_pkg::QUEUE_DEPTH));
	assign push = cmd.valid && cmd.ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_pop && q_valid;
	assign q_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/ett_div.sv
// restoring divider for elapsed/duration, one quotient bit per cycle
`default_nettype none
module ett_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ett_pkg::div_req_t req,
	output ett_pkg::div_rsp_t     rsp
);

	logic [ett_pkg::TIME_W:0]          rem_q;
	logic [ett_pkg::TIME_W-1:0]        dvs_q;
	logic [ett_pkg::RATIO_W-1:0]       quo_q;
	logic [ett_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                              busy_q;
	logic                              done_q;
	logic                              ge;
	logic [ett_pkg::TIME_W:0]          diff;

	// dividend is at most the divisor, so the top quotient bit is the first trial
	assign ge = (rem_q >= {1'b0, dvs_q});
	assign diff = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

	assign rsp = {done_q, quo_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.dividend};
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {diff[ett_pkg::TIME_W-1:0], 1'b0};
			quo_q <= {quo_q[ett_pkg::RATIO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= ett_pkg::DIV_CNT_W'(ett_pkg::RATIO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ett_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/ett_back.sv
// execution sequencer: timing state, ratio, easing, interpolation, result register
`default_nettype none
module ett_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ett_pkg::cfg_t     cfg,
	input  wire ett_pkg::cmd_t     q_word,
	input  wire logic              q_valid,
	output logic                   q_pop,
	output ett_pkg::div_req_t      div_req,
	input  wire ett_pkg::div_rsp_t div_rsp,
	ett_res_if.source              res
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_LO, S_HI, S_EMUL, S_EADD, S_MX, S_AX, S_MY, S_AY, S_FIN
	} state_t;

	state_t                               state_q;
	logic [ett_pkg::TIME_W-1:0]           elapsed_q;
	logic                                 running_q;
	logic signed [ett_pkg::COORD_W-1:0]   cur_x_q;
	logic signed [ett_pkg::COORD_W-1:0]   cur_y_q;
	logic                                 out_valid_q;
	logic signed [ett_pkg::COORD_W-1:0]   out_x_q;
	logic signed [ett_pkg::COORD_W-1:0]   out_y_q;
	logic                                 out_moved_q;
	logic                                 out_play_q;

	// datapath registers
	logic [ett_pkg::RATIO_W-1:0]              ratio_q;
	logic [ett_pkg::RATIO_W-1:0]              eased_q;
	logic [ett_pkg::IDX_W-1:0]                idx_q;
	logic [ett_pkg::RATIO_FRACTION_BITS-1:0]  frac_q;
	logic [ett_pkg::RATIO_W-1:0]              lo_q;
	logic [ett_pkg::RATIO_W-1:0]              hi_q;
	logic signed [ett_pkg::MUL_P_W-1:0]       mul_q;
	logic signed [ett_pkg::COORD_W-1:0]       nx_q;
	logic signed [ett_pkg::COORD_W-1:0]       ny_q;

	logic                                 slot_free;
	logic                                 is_adv_run;
	logic [ett_pkg::TIME_W:0]             sum;
	logic [ett_pkg::TIME_W-1:0]           sat;
	logic                                 start_run;
	logic                                 ratio_load;
	logic [ett_pkg::RATIO_W-1:0]          r_new;
	logic [ett_pkg::POS_W-1:0]            pos;
	logic [ett_pkg::IDX_W-1:0]            tab_addr;
	logic [ett_pkg::RATIO_W-1:0]          tab_rd;
	logic                                 ease_up;
	logic [ett_pkg::RATIO_W-1:0]          ease_span;
	logic [ett_pkg::RATIO_W-1:0]          ease_step;
	logic signed [ett_pkg::MUL_OP_W-1:0]  mul_a;
	logic signed [ett_pkg::MUL_OP_W-1:0]  mul_b;
	logic signed [ett_pkg::MUL_P_W-1:0]   lerp_sh;
	logic signed [ett_pkg::COORD_W:0]     dx;
	logic signed [ett_pkg::COORD_W:0]     dy;
	logic [ett_pkg::COORD_W:0]            adx;
	logic [ett_pkg::COORD_W:0]            ady;
	logic                                 moved;

	assign slot_free = !out_valid_q || res.ready;
	assign q_pop = (state_q == S_IDLE) && q_valid && slot_free;
	assign is_adv_run = (q_word.act == ett_pkg::ACT_ADVANCE) && running_q;

	// elapsed time saturates at the duration
	assign sum = {1'b0, elapsed_q} + (ett_pkg::TIME_W + 1)'(q_word.delta);
	assign sat = (sum > {1'b0, cfg.duration}) ? cfg.duration : sum[ett_pkg::TIME_W-1:0];
	assign start_run = (cfg.duration != '0);

	// divider request: start, dividend, divisor
	assign div_req = {q_pop && is_adv_run && start_run, sat, cfg.duration};

	// ratio becomes known either from the divider or at once for zero duration
	assign ratio_load = (q_pop && is_adv_run && !start_run)
		|| ((state_q == S_DIV) && div_rsp.done);
	assign r_new = (state_q == S_DIV) ? div_rsp.quotient : ett_pkg::ONE_RATIO;
	assign pos = ett_pkg::POS_W'(r_new) * ett_pkg::POS_W'(ett_pkg::EASE_TABLE_DEPTH);

	// one lookup port: low entry, then the next one up
	assign tab_addr = ((state_q == S_HI) && (idx_q != ett_pkg::IDX_MAX)) ? idx_q + 1'b1 : idx_q;
	assign tab_rd = ett_pkg::EASE_TAB[tab_addr];

	assign ease_up = (hi_q >= lo_q);
	assign ease_span = ease_up ? (hi_q - lo_q) : (lo_q - hi_q);
	assign ease_step = mul_q[ett_pkg::RATIO_FRACTION_BITS +: ett_pkg::RATIO_W];

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			S_MX: begin
				mul_a = ett_pkg::MUL_OP_W'(cfg.end_x) - ett_pkg::MUL_OP_W'(cfg.start_x);
				mul_b = ett_pkg::MUL_OP_W'(eased_q);
			end
			S_MY: begin
				mul_a = ett_pkg::MUL_OP_W'(cfg.end_y) - ett_pkg::MUL_OP_W'(cfg.start_y);
				mul_b = ett_pkg::MUL_OP_W'(eased_q);
			end
			default: begin
				mul_a = ett_pkg::MUL_OP_W'(ease_span);
				mul_b = ett_pkg::MUL_OP_W'(frac_q);
			end
		endcase
	end

	// round half up, then floor shift
	assign lerp_sh = (mul_q + (ett_pkg::MUL_P_W'(1) << (ett_pkg::RATIO_FRACTION_BITS - 1)))
		>>> ett_pkg::RATIO_FRACTION_BITS;

	assign dx = {nx_q[ett_pkg::COORD_W-1], nx_q} - {cur_x_q[ett_pkg::COORD_W-1], cur_x_q};
	assign dy = {ny_q[ett_pkg::COORD_W-1], ny_q} - {cur_y_q[ett_pkg::COORD_W-1], cur_y_q};
	assign adx = dx[ett_pkg::COORD_W] ? (ett_pkg::COORD_W + 1)'(-dx) : dx;
	assign ady = dy[ett_pkg::COORD_W] ? (ett_pkg::COORD_W + 1)'(-dy) : dy;
	assign moved = (adx > (ett_pkg::COORD_W + 1)'(cfg.tol))
		|| (ady > (ett_pkg::COORD_W + 1)'(cfg.tol));

	assign res.valid = out_valid_q;
	assign res.offset_x = out_x_q;
	assign res.offset_y = out_y_q;
	assign res.moved = out_moved_q;
	assign res.playing = out_play_q;

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (ratio_load) begin
			ratio_q <= r_new;
			eased_q <= r_new;
			idx_q <= pos[ett_pkg::RATIO_FRACTION_BITS +: ett_pkg::IDX_W];
			frac_q <= pos[ett_pkg::RATIO_FRACTION_BITS-1:0];
		end
		if (state_q == S_LO) lo_q <= tab_rd;
		if (state_q == S_HI) hi_q <= tab_rd;
		if (state_q == S_EADD) begin
			if (idx_q == ett_pkg::IDX_MAX) eased_q <= lo_q;
			else if (ease_up) eased_q <= lo_q + ease_step;
			else eased_q <= lo_q - ease_step;
		end
		if (state_q == S_AX) nx_q <= cfg.start_x + lerp_sh[ett_pkg::COORD_W-1:0];
		if (state_q == S_AY) ny_q <= cfg.start_y + lerp_sh[ett_pkg::COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			elapsed_q <= '0;
			running_q <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			out_valid_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_moved_q <= 1'b0;
			out_play_q <= 1'b0;
		end else begin
			if (res.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						out_moved_q <= 1'b0;
						out_x_q <= cur_x_q;
						out_y_q <= cur_y_q;
						out_play_q <= running_q;
						unique case (q_word.act)
							ett_pkg::ACT_START: begin
								elapsed_q <= '0;
								running_q <= start_run;
								cur_x_q <= start_run ? cfg.start_x : cfg.end_x;
								cur_y_q <= start_run ? cfg.start_y : cfg.end_y;
								out_x_q <= start_run ? cfg.start_x : cfg.end_x;
								out_y_q <= start_run ? cfg.start_y : cfg.end_y;
								out_play_q <= start_run;
								out_valid_q <= 1'b1;
							end
							ett_pkg::ACT_STOP: begin
								elapsed_q <= '0;
								running_q <= 1'b0;
								out_play_q <= 1'b0;
								out_valid_q <= 1'b1;
							end
							ett_pkg::ACT_ADVANCE: begin
								if (running_q) begin
									elapsed_q <= sat;
									if (start_run) state_q <= S_DIV;
									else state_q <= cfg.ease_cos ? S_LO : S_MX;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_rsp.done) state_q <= cfg.ease_cos ? S_LO : S_MX;
				end
				S_LO:   state_q <= S_HI;
				S_HI:   state_q <= S_EMUL;
				S_EMUL: state_q <= S_EADD;
				S_EADD: state_q <= S_MX;
				S_MX:   state_q <= S_AX;
				S_AX:   state_q <= S_MY;
				S_MY:   state_q <= S_AY;
				S_AY:   state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) begin
						cur_x_q <= nx_q;
						cur_y_q <= ny_q;
						running_q <= (ratio_q != ett_pkg::ONE_RATIO);
						out_x_q <= nx_q;
						out_y_q <= ny_q;
						out_moved_q <= moved;
						out_play_q <= (ratio_q != ett_pkg::ONE_RATIO);
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### verif/eased_translation_tween_checker.sv
// result checker for the tween core: tracks the settings, predicts each result word, compares
`timescale 1ns / 1ps
module eased_translation_tween_checker
	import ett_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	ett_cmd_if                         cmd,
	ett_res_if                         res,
	output int                         failures,
	output int                         pending
);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      moved;
		logic                      playing;
	} offset_word_t;

	cfg_t                      cfg;
	logic [TIME_W-1:0]         elapsed;
	logic                      running;
	logic signed [COORD_W-1:0] cur_x;
	logic signed [COORD_W-1:0] cur_y;
	logic [RATIO_W-1:0]        cos_tab [EASE_TABLE_DEPTH+1];
	offset_word_t              offsets_due [$];
	offset_word_t              due;
	int                        mismatches;

	// half-period cosine ease in Q1.16, series in Q30, lower half only
	function automatic logic [RATIO_W-1:0] cos_ease_entry(int j);
		logic [63:0] ang;
		logic [63:0] ang_sq;
		logic [63:0] term;
		longint      cos_acc;
		longint      eased;
		ang = (PI_Q30 * 64'(j)) / 64'(EASE_TABLE_DEPTH);
		ang_sq = (ang * ang) >> 30;
		term = ONE_Q30;
		cos_acc = longint'(ONE_Q30);
		for (int k = 1; k <= 10; k++) begin
			term = ((term * ang_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) cos_acc -= longint'(term);
			else cos_acc += longint'(term);
		end
		if (cos_acc > longint'(ONE_Q30)) cos_acc = longint'(ONE_Q30);
		if (cos_acc < -longint'(ONE_Q30)) cos_acc = -longint'(ONE_Q30);
		eased = longint'(ONE_Q30) - cos_acc;
		eased = (eased + (longint'(1) << (30 - RATIO_FRACTION_BITS))) >>> (31 - RATIO_FRACTION_BITS);
		if (eased > (longint'(1) << RATIO_FRACTION_BITS)) eased = longint'(1) << RATIO_FRACTION_BITS;
		return RATIO_W'(eased);
	endfunction

	initial begin
		for (int j = 0; j <= EASE_TABLE_DEPTH; j++) begin
			if (2 * j <= EASE_TABLE_DEPTH) cos_tab[j] = cos_ease_entry(j);
			else cos_tab[j] = ONE_RATIO - cos_tab[EASE_TABLE_DEPTH - j];
		end
	end

	// table lookup with floored linear interpolation between entries
	function automatic logic [RATIO_W-1:0] cos_ease(logic [RATIO_W-1:0] ratio);
		logic [63:0] pos;
		logic [63:0] idx;
		logic [63:0] frac;
		logic [63:0] lo;
		logic [63:0] hi;
		pos = 64'(ratio) * 64'(EASE_TABLE_DEPTH);
		idx = pos >> RATIO_FRACTION_BITS;
		frac = pos & ((64'd1 << RATIO_FRACTION_BITS) - 64'd1);
		if (idx >= 64'(EASE_TABLE_DEPTH)) return cos_tab[EASE_TABLE_DEPTH];
		lo = 64'(cos_tab[idx]);
		hi = 64'(cos_tab[idx + 1]);
		if (hi >= lo) return RATIO_W'(lo + (((hi - lo) * frac) >> RATIO_FRACTION_BITS));
		return RATIO_W'(lo - (((lo - hi) * frac) >> RATIO_FRACTION_BITS));
	endfunction

	// start + round half up of (end - start) * eased
	function automatic logic signed [COORD_W-1:0] blend(logic signed [COORD_W-1:0] a,
			logic signed [COORD_W-1:0] b, logic [RATIO_W-1:0] eased);
		longint prod;
		prod = (longint'(b) - longint'(a)) * longint'(eased)
			+ (longint'(1) << (RATIO_FRACTION_BITS - 1));
		return COORD_W'(longint'(a) + (prod >>> RATIO_FRACTION_BITS));
	endfunction

	function automatic offset_word_t step_tween(action_t act, logic [DELTA_W-1:0] dt);
		offset_word_t              w;
		longint                    sum;
		longint                    dx;
		longint                    dy;
		logic [RATIO_W-1:0]        ratio;
		logic [RATIO_W-1:0]        eased;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		w.moved = 1'b0;
		case (act)
			ACT_START: begin
				elapsed = '0;
				running = (cfg.duration != '0);
				cur_x = running ? cfg.start_x : cfg.end_x;
				cur_y = running ? cfg.start_y : cfg.end_y;
			end
			ACT_STOP: begin
				running = 1'b0;
				elapsed = '0;
			end
			ACT_ADVANCE: begin
				if (running) begin
					px = cur_x;
					py = cur_y;
					sum = longint'(elapsed) + longint'(dt);
					if (sum > longint'(cfg.duration)) sum = longint'(cfg.duration);
					elapsed = TIME_W'(sum);
					if (cfg.duration == '0) ratio = ONE_RATIO;
					else ratio = RATIO_W'((64'(elapsed) << RATIO_FRACTION_BITS) / 64'(cfg.duration));
					eased = cfg.ease_cos ? cos_ease(ratio) : ratio;
					cur_x = blend(cfg.start_x, cfg.end_x, eased);
					cur_y = blend(cfg.start_y, cfg.end_y, eased);
					if (ratio == ONE_RATIO) running = 1'b0;
					dx = longint'(cur_x) - longint'(px);
					dy = longint'(cur_y) - longint'(py);
					if (dx < 0) dx = -dx;
					if (dy < 0) dy = -dy;
					w.moved = (dx > longint'(cfg.tol)) || (dy > longint'(cfg.tol));
				end
			end
			default: ;
		endcase
		w.x = cur_x;
		w.y = cur_y;
		w.playing = running;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '0;
			elapsed = '0;
			running = 1'b0;
			cur_x = '0;
			cur_y = '0;
			offsets_due.delete();
			mismatches = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (offsets_due.size() == 0) begin
					$error("result word with none expected: x %0d y %0d", res.offset_x, res.offset_y);
					mismatches++;
				end else begin
					due = offsets_due.pop_front();
					if (res.offset_x !== due.x) begin
						$error("offset_x: expected %0d, actual %0d", due.x, res.offset_x);
						mismatches++;
					end
					if (res.offset_y !== due.y) begin
						$error("offset_y: expected %0d, actual %0d", due.y, res.offset_y);
						mismatches++;
					end
					if (res.moved !== due.moved) begin
						$error("moved: expected %0d, actual %0d", due.moved, res.moved);
						mismatches++;
					end
					if (res.playing !== due.playing) begin
						$error("playing: expected %0d, actual %0d", due.playing, res.playing);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X:   cfg.start_x  = cfg_data[COORD_W-1:0];
					REG_START_Y:   cfg.start_y  = cfg_data[COORD_W-1:0];
					REG_END_X:     cfg.end_x    = cfg_data[COORD_W-1:0];
					REG_END_Y:     cfg.end_y    = cfg_data[COORD_W-1:0];
					REG_DURATION:  cfg.duration = cfg_data[TIME_W-1:0];
					REG_EASE_MODE: cfg.ease_cos = cfg_data[0];
					REG_TOLERANCE: cfg.tol      = cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				offsets_due.push_back(step_tween(action_t'(cmd.action), cmd.delta_ticks));
			failures <= mismatches;
			pending <= offsets_due.size();
		end
	end

endmodule

### verif/eased_translation_tween_core_tb.sv
// testbench top for the tween core: clock, reset, settings, command words and the verdict
`timescale 1ns / 1ps
module eased_translation_tween_core_tb;
	import ett_pkg::*;

	localparam int ITEM_TARGET = 1300;
	// slowest run is roughly 1400 words plus settling between phases
	localparam int CYCLE_LIMIT = 400000;
	// settling time after the last word so that a late result word still comes out
	localparam int TAIL_CYCLES = 40;
	// no register lives here, writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int NUM_REGS = 8;
	// last stretch of the run goes without any idling
	localparam int QUIET_TAIL = 150;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    failures;
	int                    pending;
	int                    cycle_count = 0;
	int                    words_sent = 0;
	bit                    send_gaps = 1'b0;
	bit                    sink_gaps = 1'b0;
	// shadow of what was last written to each register index
	logic [CFG_DATA_W-1:0] setting [NUM_REGS];

	ett_cmd_if cmd ();
	ett_res_if res ();

	eased_translation_tween_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res       (res)
	);

	eased_translation_tween_checker tween_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res       (res),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side back-pressure, random bursts with ready held low
	initial begin
		res.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (sink_gaps && $urandom_range(0, 4) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				res.ready <= 1'b1;
			end
		end
	end

	function automatic bit [NUM_REGS-1:0] reg_bit(logic [CFG_IDX_W-1:0] idx);
		return NUM_REGS'(1) << idx;
	endfunction

	// one command word; valid stays up after acceptance so back-to-back words need no extra edge
	task automatic send_word(action_t act, logic [DELTA_W-1:0] dt);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.action <= act;
		cmd.delta_ticks <= dt;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		if (act != ACT_NOP) words_sent++;
	endtask

	// hold off the sender until every expected word has come back
	task automatic wait_idle();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// write the selected registers from the shadow, only once the core is idle
	task automatic load_settings(bit [NUM_REGS-1:0] mask);
		wait_idle();
		for (int i = 0; i < NUM_REGS; i++) begin
			if (mask[i]) begin
				cfg_we <= 1'b1;
				cfg_index <= CFG_IDX_W'(i);
				cfg_data <= setting[i];
				@(posedge clk);
			end
		end
		cfg_we <= 1'b0;
	endtask

	// new random settings, then a run of words that mostly plays the tween through
	task automatic random_phase();
		bit [NUM_REGS-1:0]  mask;
		logic [COORD_W-1:0] coord;
		logic [TIME_W-1:0]  dur;
		logic [TOL_W-1:0]   tol;
		logic [DELTA_W-1:0] dt;
		int                 run_len;
		int                 span;
		int                 stride;
		mask = NUM_REGS'($urandom());
		for (int i = 0; i < NUM_REGS; i++) begin
			if (mask[i]) begin
				case (CFG_IDX_W'(i))
					REG_START_X, REG_START_Y, REG_END_X, REG_END_Y: begin
						case ($urandom_range(0, 5))
							0: coord = 16'h8000;
							1: coord = 16'h7FFF;
							2: coord = COORD_W'($urandom_range(0, 64));
							default: coord = COORD_W'($urandom());
						endcase
						// upper data bits are don't-care for 16-bit registers
						setting[i] = {8'($urandom()), coord};
					end
					REG_DURATION: begin
						// mostly short runs so that many tweens finish
						case ($urandom_range(0, 9))
							0: dur = '0;
							1, 2, 3, 4, 5, 6: dur = TIME_W'($urandom_range(1, 64));
							7, 8: dur = TIME_W'($urandom_range(65, 300000));
							default: dur = $urandom_range(0, 1) ? '1 : TIME_W'($urandom());
						endcase
						setting[i] = dur;
					end
					REG_EASE_MODE: setting[i] = {23'($urandom()), 1'($urandom())};
					REG_TOLERANCE: begin
						case ($urandom_range(0, 9))
							0, 1, 2: tol = '0;
							3: tol = '1;
							default: tol = TOL_W'($urandom_range(0, 40));
						endcase
						setting[i] = {16'($urandom()), tol};
					end
					default: setting[i] = CFG_DATA_W'($urandom());
				endcase
			end
		end
		load_settings(mask);
		span = int'(setting[REG_DURATION][TIME_W-1:0]);
		// skipping the start now and then keeps a tween running across new settings
		if ($urandom_range(0, 4) != 0) send_word(ACT_START, DELTA_W'($urandom()));
		run_len = $urandom_range(6, 30);
		for (int n = 0; n < run_len; n++) begin
			case ($urandom_range(0, 19))
				0: send_word(ACT_STOP, DELTA_W'($urandom()));
				1: send_word(ACT_NOP, DELTA_W'($urandom()));
				2: send_word(ACT_START, DELTA_W'($urandom()));
				default: begin
					case ($urandom_range(0, 9))
						0: dt = '0;
						1: dt = '1;
						2, 3: dt = DELTA_W'($urandom());
						default: begin
							stride = $urandom_range(0, span / 4 + 1);
							if (stride > 65535) stride = 65535;
							dt = DELTA_W'(stride);
						end
					endcase
					send_word(ACT_ADVANCE, dt);
				end
			endcase
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cmd.valid <= 1'b0;
		cmd.action <= ACT_NOP;
		cmd.delta_ticks <= '0;
		for (int i = 0; i < NUM_REGS; i++) setting[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight out of reset: advance while stopped, no-op, start with zero duration
		// jumps to the zero end point without playing, then stop
		send_word(ACT_ADVANCE, 16'hFFFF);
		send_word(ACT_NOP, 16'h0000);
		send_word(ACT_START, 16'hA5A5);
		send_word(ACT_STOP, 16'h5A5A);

		// full-scale sweep in one tick, linear, zero tolerance; index 7 write is dropped
		setting[REG_START_X]   = 24'h00_8000;
		setting[REG_START_Y]   = 24'h00_7FFF;
		setting[REG_END_X]     = 24'h00_7FFF;
		setting[REG_END_Y]     = 24'h00_8000;
		setting[REG_DURATION]  = 24'd1;
		setting[REG_EASE_MODE] = 24'd0;
		setting[REG_TOLERANCE] = 24'd0;
		setting[REG_UNUSED]    = 24'hFFFFFF;
		load_settings('1);
		send_word(ACT_START, 16'h0000);
		send_word(ACT_ADVANCE, 16'h0000);
		send_word(ACT_ADVANCE, 16'h0001);
		send_word(ACT_ADVANCE, 16'hFFFF);

		// longest duration, cosine ease, widest tolerance so small steps count as unchanged
		setting[REG_START_X]   = 24'h00_7FFF;
		setting[REG_START_Y]   = 24'h00_8000;
		setting[REG_END_X]     = 24'h00_8000;
		setting[REG_END_Y]     = 24'h00_7FFF;
		setting[REG_DURATION]  = 24'hFFFFFF;
		setting[REG_EASE_MODE] = 24'd1;
		setting[REG_TOLERANCE] = 24'd255;
		load_settings(reg_bit(REG_START_X) | reg_bit(REG_START_Y) | reg_bit(REG_END_X)
			| reg_bit(REG_END_Y) | reg_bit(REG_DURATION) | reg_bit(REG_EASE_MODE)
			| reg_bit(REG_TOLERANCE));
		send_word(ACT_START, 16'h0000);
		send_word(ACT_ADVANCE, 16'hFFFF);
		send_word(ACT_ADVANCE, 16'hFFFF);
		send_word(ACT_ADVANCE, 16'hFFFF);
		send_word(ACT_STOP, 16'h0000);
		send_word(ACT_ADVANCE, 16'h0001);

		// duration cut to zero mid-play: next advance lands on the end point and stops
		setting[REG_DURATION]  = 24'd100;
		setting[REG_TOLERANCE] = 24'd0;
		load_settings(reg_bit(REG_DURATION) | reg_bit(REG_TOLERANCE));
		send_word(ACT_START, 16'h0000);
		send_word(ACT_ADVANCE, 16'd30);
		setting[REG_DURATION] = 24'd0;
		load_settings(reg_bit(REG_DURATION));
		send_word(ACT_ADVANCE, 16'd5);
		send_word(ACT_START, 16'h0000);

		// duration lowered below the elapsed time: elapsed clamps, ratio reaches one
		setting[REG_DURATION] = 24'd100;
		load_settings(reg_bit(REG_DURATION));
		send_word(ACT_START, 16'h0000);
		send_word(ACT_ADVANCE, 16'd60);
		setting[REG_DURATION] = 24'd40;
		load_settings(reg_bit(REG_DURATION));
		send_word(ACT_ADVANCE, 16'd0);

		// random phases; idling is toggled per phase and switched off near the end
		while (words_sent < ITEM_TARGET) begin
			send_gaps = (words_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			sink_gaps = (words_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			random_phase();
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
rtl/ett_pkg.sv
rtl/ett_if.sv
rtl/ett_front.sv
rtl/ett_div.sv
rtl/ett_back.sv
rtl/eased_translation_tween_core.sv
verif/eased_translation_tween_checker.sv
verif/eased_translation_tween_core_tb.sv
